>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL that checks itself.
// Each macro expects clk and rst_n to be visible at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/etcm_pkg.sv
// Shared types and constants of the elevation tint pipeline.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package etcm_pkg;

  localparam int ElevW    = 16;
  localparam int OffW     = 13;
  localparam int NumAW    = 17;
  localparam int NumBW    = 14;
  localparam int QuotW    = 9;
  localparam int ProdW    = 35;
  localparam int ChanW    = 8;

  localparam int DepthSat = 5000;
  localparam int ElevSat  = 8000;
  localparam int GreenTop = 1600;
  localparam int BrownTop = 4800;

  // floor(p / 1000) = (p * RecipK) >> RecipShift for p below 2^27 / 272
  localparam int RecipK     = 134218;
  localparam int RecipShift = 27;
  // floor(y / 5) = (y * Recip5) >> Recip5Shift for y below 1024
  localparam int Recip5      = 205;
  localparam int Recip5Shift = 10;

  localparam int WaterBase = 150;
  localparam int LowBase   = 180;
  localparam int MtnRed    = 139;
  localparam int MtnGreen  = 69;
  localparam int MtnBlue   = 19;
  localparam int SnowBase  = 200;

  typedef enum logic [1:0] {
    BAND_WATER,
    BAND_LOW,
    BAND_MOUNT,
    BAND_SNOW
  } band_t;

  // After classification: band and saturated offset into it.
  typedef struct packed {
    band_t           band;
    logic [OffW-1:0] off;
  } s1_t;

  // After scaling: numerators ready for the constant divides.
  typedef struct packed {
    band_t            band;
    logic [NumAW-1:0] num_a;
    logic [NumBW-1:0] num_b;
  } s2_t;

  // After the reciprocal multiply: direct channel and product.
  typedef struct packed {
    band_t            band;
    logic [ChanW-1:0] qd;
    logic [ProdW-1:0] prod;
  } s3_t;

endpackage

>>> rtl/core/etcm_classify.sv
// Stage 1: sort the elevation sample into a band and saturate its offset.
// Depends on etcm_pkg.
`timescale 1ns / 1ps

module etcm_classify (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [etcm_pkg::ElevW-1:0] elev,
  output etcm_pkg::s1_t                     s1_r
);

  logic [etcm_pkg::ElevW:0]     depth;
  logic [etcm_pkg::OffW-1:0]    depth_sat;
  logic [etcm_pkg::ElevW-2:0]   land;
  logic [etcm_pkg::OffW-1:0]    land_sat;
  etcm_pkg::s1_t                s1_nxt;

  always_comb begin
    depth     = (etcm_pkg::ElevW+1)'(0) - {elev[etcm_pkg::ElevW-1], elev};
    depth_sat = (depth > (etcm_pkg::ElevW+1)'(etcm_pkg::DepthSat)) ?
                etcm_pkg::OffW'(etcm_pkg::DepthSat) : depth[etcm_pkg::OffW-1:0];
    land      = elev[etcm_pkg::ElevW-2:0];
    land_sat  = (land > (etcm_pkg::ElevW-1)'(etcm_pkg::ElevSat)) ?
                etcm_pkg::OffW'(etcm_pkg::ElevSat) : land[etcm_pkg::OffW-1:0];

    if (elev[etcm_pkg::ElevW-1]) begin
      s1_nxt.band = etcm_pkg::BAND_WATER;
      s1_nxt.off  = etcm_pkg::OffW'(etcm_pkg::DepthSat) - depth_sat;
    end else if (land_sat < etcm_pkg::OffW'(etcm_pkg::GreenTop)) begin
      s1_nxt.band = etcm_pkg::BAND_LOW;
      s1_nxt.off  = land_sat;
    end else if (land_sat < etcm_pkg::OffW'(etcm_pkg::BrownTop)) begin
      s1_nxt.band = etcm_pkg::BAND_MOUNT;
      s1_nxt.off  = land_sat - etcm_pkg::OffW'(etcm_pkg::GreenTop);
    end else begin
      s1_nxt.band = etcm_pkg::BAND_SNOW;
      s1_nxt.off  = land_sat - etcm_pkg::OffW'(etcm_pkg::BrownTop);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
    end
  end

endmodule

>>> rtl/core/etcm_scale.sv
// Stage 2: scale the band offset into the numerators of each ramp.
// Depends on etcm_pkg.
`timescale 1ns / 1ps

module etcm_scale (
  input  logic          clk,
  input  logic          en,
  input  etcm_pkg::s1_t s1,
  output etcm_pkg::s2_t s2_r
);

  etcm_pkg::s2_t                   s2_nxt;
  logic [etcm_pkg::NumAW-1:0]      off_a;
  logic [etcm_pkg::NumBW-1:0]      off_b;

  always_comb begin
    off_a       = etcm_pkg::NumAW'(s1.off);
    off_b       = etcm_pkg::NumBW'(s1.off);
    s2_nxt.band = s1.band;
    s2_nxt.num_b = '0;
    case (s1.band)
      // 105*x/5000 reduces to 21*x/1000
      etcm_pkg::BAND_WATER: s2_nxt.num_a = off_a * etcm_pkg::NumAW'(21);
      // 75*u/1600 reduces to 3*u/64
      etcm_pkg::BAND_LOW:   s2_nxt.num_a = off_a * etcm_pkg::NumAW'(3);
      // red t/64, green 3*t/320
      etcm_pkg::BAND_MOUNT: begin
        s2_nxt.num_a = off_a;
        s2_nxt.num_b = off_b * etcm_pkg::NumBW'(3);
      end
      // 55*t/3200 reduces to 11*t/640
      etcm_pkg::BAND_SNOW:  s2_nxt.num_a = off_a * etcm_pkg::NumAW'(11);
      default:              s2_nxt.num_a = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r <= s2_nxt;
    end
  end

endmodule

>>> rtl/core/etcm_divide.sv
// Stage 3: power-of-two shifts and one reciprocal multiply per sample.
// Depends on etcm_pkg.
`timescale 1ns / 1ps

module etcm_divide (
  input  logic          clk,
  input  logic          en,
  input  etcm_pkg::s2_t s2,
  output etcm_pkg::s3_t s3_r
);

  etcm_pkg::s3_t                   s3_nxt;
  logic [etcm_pkg::QuotW-1:0]      y;
  logic [etcm_pkg::ProdW-1:0]      mul_a;
  logic [etcm_pkg::ProdW-1:0]      mul_k;
  logic [etcm_pkg::ChanW-1:0]      shr6;

  always_comb begin
    shr6 = etcm_pkg::ChanW'(s2.num_a >> 6);
    // operand of the divide-by-five: floor(3t/64) or floor(11t/128)
    if (s2.band == etcm_pkg::BAND_MOUNT) begin
      y = etcm_pkg::QuotW'(s2.num_b >> 6);
    end else begin
      y = etcm_pkg::QuotW'(s2.num_a >> 7);
    end

    if (s2.band == etcm_pkg::BAND_WATER) begin
      mul_a = etcm_pkg::ProdW'(s2.num_a);
      mul_k = etcm_pkg::ProdW'(etcm_pkg::RecipK);
    end else begin
      mul_a = etcm_pkg::ProdW'(y);
      mul_k = etcm_pkg::ProdW'(etcm_pkg::Recip5);
    end

    s3_nxt.band = s2.band;
    s3_nxt.prod = mul_a * mul_k;
    case (s2.band)
      etcm_pkg::BAND_LOW:   s3_nxt.qd = etcm_pkg::ChanW'(etcm_pkg::LowBase) + shr6;
      etcm_pkg::BAND_MOUNT: s3_nxt.qd = etcm_pkg::ChanW'(etcm_pkg::MtnRed) + shr6;
      default:              s3_nxt.qd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_r <= s3_nxt;
    end
  end

endmodule

>>> rtl/core/elevation_to_color_map.sv
// Hypsometric tint: one signed elevation sample in meters in, one RGB pixel
// out. The block takes a sample in every clock while in_stall is low and
// delivers one pixel per sample through four register stages
// (classify, scale, reciprocal multiply, color assembly). A stage advances
// whenever it is empty or the one after it advances, so bubbles close up and
// in_stall rises only when all four stages hold data and out_stall is high.
// Depends on etcm_pkg, etcm_classify, etcm_scale, etcm_divide and
// assert_macros.svh.
`timescale 1ns / 1ps

module elevation_to_color_map (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [etcm_pkg::ElevW-1:0] in_elevation_m,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [etcm_pkg::ChanW-1:0]        out_red,
  output logic [etcm_pkg::ChanW-1:0]        out_green,
  output logic [etcm_pkg::ChanW-1:0]        out_blue
);

  logic v1_r, v2_r, v3_r, vo_r;
  logic en1, en2, en3, en_o;

  etcm_pkg::s1_t s1;
  etcm_pkg::s2_t s2;
  etcm_pkg::s3_t s3;

  logic [etcm_pkg::ChanW-1:0] q5;
  logic [etcm_pkg::ChanW-1:0] qw;
  logic [etcm_pkg::ChanW-1:0] red_nxt, green_nxt, blue_nxt;
  logic [etcm_pkg::ChanW-1:0] red_r, green_r, blue_r;

  assign en_o     = !vo_r || !out_stall;
  assign en3      = !v3_r || en_o;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_stall = !en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (en1)  v1_r <= in_valid;
      if (en2)  v2_r <= v1_r;
      if (en3)  v3_r <= v2_r;
      if (en_o) vo_r <= v3_r;
    end
  end

  etcm_classify u_classify (
    .clk  (clk),
    .en   (en1),
    .elev (in_elevation_m),
    .s1_r (s1)
  );

  etcm_scale u_scale (
    .clk  (clk),
    .en   (en2),
    .s1   (s1),
    .s2_r (s2)
  );

  etcm_divide u_divide (
    .clk  (clk),
    .en   (en3),
    .s2   (s2),
    .s3_r (s3)
  );

  // finish the divides: drop the low product bits
  assign qw = s3.prod[etcm_pkg::RecipShift +: etcm_pkg::ChanW];
  assign q5 = s3.prod[etcm_pkg::Recip5Shift +: etcm_pkg::ChanW];

  always_comb begin
    case (s3.band)
      etcm_pkg::BAND_WATER: begin
        red_nxt   = '0;
        green_nxt = '0;
        blue_nxt  = etcm_pkg::ChanW'(etcm_pkg::WaterBase) + qw;
      end
      etcm_pkg::BAND_LOW: begin
        red_nxt   = '0;
        green_nxt = s3.qd;
        blue_nxt  = '0;
      end
      etcm_pkg::BAND_MOUNT: begin
        red_nxt   = s3.qd;
        green_nxt = etcm_pkg::ChanW'(etcm_pkg::MtnGreen) + q5;
        blue_nxt  = etcm_pkg::ChanW'(etcm_pkg::MtnBlue);
      end
      default: begin
        red_nxt   = etcm_pkg::ChanW'(etcm_pkg::SnowBase) + q5;
        green_nxt = etcm_pkg::ChanW'(etcm_pkg::SnowBase) + q5;
        blue_nxt  = etcm_pkg::ChanW'(etcm_pkg::SnowBase) + q5;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en_o) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_valid = vo_r;
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

`include "assert_macros.svh"

  `ASSERT_IMPL(a_stall_only_full, in_stall, v1_r && v2_r && v3_r && vo_r,
               "stall with a free stage")
  `ASSERT_IMPL(a_drain_no_stall, !out_stall, !in_stall, "input stalled while output drains")
  `ASSERT_NEXT(a_accept_enters, in_valid && !in_stall, v1_r,
               "accepted sample lost at stage one")
  `ASSERT_IMPL(a_snow_gray, out_valid && (out_red >= etcm_pkg::ChanW'(etcm_pkg::SnowBase)),
               (out_green == out_red) && (out_blue == out_red), "snow pixel not gray")

endmodule

>>> verif/etcm_tint_checker.sv
// Tint checker: watches both channels of elevation_to_color_map, predicts each
// pixel from the accepted elevation and compares it with the delivered pixel.
// Depends on etcm_pkg for widths and color constants.
`timescale 1ns / 1ps

module etcm_tint_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic signed [etcm_pkg::ElevW-1:0] in_elevation_m,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [etcm_pkg::ChanW-1:0]        out_red,
  input  logic [etcm_pkg::ChanW-1:0]        out_green,
  input  logic [etcm_pkg::ChanW-1:0]        out_blue,
  output int                                mismatches,
  output int                                pixels_pending,
  output int                                pixels_checked
);

  typedef struct {
    logic signed [etcm_pkg::ElevW-1:0] elev;
    logic [etcm_pkg::ChanW-1:0]        red;
    logic [etcm_pkg::ChanW-1:0]        green;
    logic [etcm_pkg::ChanW-1:0]        blue;
  } tint_pixel_t;

  tint_pixel_t pixel_q[$];

  function automatic tint_pixel_t tint_of(input logic signed [etcm_pkg::ElevW-1:0] elev);
    tint_pixel_t px;
    int e;
    int d;
    int t;
    int span;
    px.elev = elev;
    e = elev;
    span = etcm_pkg::BrownTop - etcm_pkg::GreenTop;
    if (e < 0) begin
      d = -e;
      if (d > etcm_pkg::DepthSat) d = etcm_pkg::DepthSat;
      px.red   = '0;
      px.green = '0;
      px.blue  = etcm_pkg::ChanW'(etcm_pkg::WaterBase +
                 (105 * (etcm_pkg::DepthSat - d)) / etcm_pkg::DepthSat);
    end else begin
      if (e > etcm_pkg::ElevSat) e = etcm_pkg::ElevSat;
      if (e < etcm_pkg::GreenTop) begin
        px.red   = '0;
        px.green = etcm_pkg::ChanW'(etcm_pkg::LowBase + (75 * e) / etcm_pkg::GreenTop);
        px.blue  = '0;
      end else if (e < etcm_pkg::BrownTop) begin
        t = e - etcm_pkg::GreenTop;
        px.red   = etcm_pkg::ChanW'(etcm_pkg::MtnRed + (50 * t) / span);
        px.green = etcm_pkg::ChanW'(etcm_pkg::MtnGreen + (30 * t) / span);
        px.blue  = etcm_pkg::ChanW'(etcm_pkg::MtnBlue);
      end else begin
        t = e - etcm_pkg::BrownTop;
        px.red   = etcm_pkg::ChanW'(etcm_pkg::SnowBase + (55 * t) / span);
        px.green = px.red;
        px.blue  = px.red;
      end
    end
    return px;
  endfunction

  task automatic compare_channel(input string chan,
                                 input logic signed [etcm_pkg::ElevW-1:0] elev,
                                 input logic [etcm_pkg::ChanW-1:0] want,
                                 input logic [etcm_pkg::ChanW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch for elevation %0d: expected %0d, got %0d",
               $time, chan, elev, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    tint_pixel_t want;
    if (rst_n) begin
      // retire first so a pixel can never match its own sample
      if (out_valid && !out_stall) begin
        if (pixel_q.size() == 0) begin
          $display("%0t: unexpected pixel: expected none, got (%0d,%0d,%0d)",
                   $time, out_red, out_green, out_blue);
          mismatches++;
        end else begin
          want = pixel_q.pop_front();
          compare_channel("red", want.elev, want.red, out_red);
          compare_channel("green", want.elev, want.green, out_green);
          compare_channel("blue", want.elev, want.blue, out_blue);
          pixels_checked++;
        end
      end
      if (in_valid && !in_stall) pixel_q.push_back(tint_of(in_elevation_m));
      pixels_pending = pixel_q.size();
    end
  end

endmodule

>>> verif/tb_elevation_to_color_map.sv
// Top of the elevation_to_color_map testbench: clock, reset, elevation
// stimulus, output back-pressure, watchdog and verdict.
// Depends on etcm_pkg, the block itself and etcm_tint_checker.
`timescale 1ns / 1ps

module tb_elevation_to_color_map;

  localparam int RandomSamples = 1700;
  localparam int IdleLimit     = 1000;
  localparam int LongHold      = 64;

  typedef enum {
    DRAIN_FREE,
    DRAIN_LIGHT,
    DRAIN_HALF,
    DRAIN_HEAVY
  } drain_mode_t;

  logic                              clk = 1'b0;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_stall;
  logic signed [etcm_pkg::ElevW-1:0] in_elevation_m;
  logic                              out_valid;
  logic                              out_stall;
  logic [etcm_pkg::ChanW-1:0]        out_red;
  logic [etcm_pkg::ChanW-1:0]        out_green;
  logic [etcm_pkg::ChanW-1:0]        out_blue;

  int mismatches;
  int pixels_pending;
  int pixels_checked;
  int idle_cycles;
  int burst_left;

  elevation_to_color_map dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_elevation_m (in_elevation_m),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue)
  );

  etcm_tint_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_elevation_m (in_elevation_m),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .mismatches     (mismatches),
    .pixels_pending (pixels_pending),
    .pixels_checked (pixels_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one sample and hold it until the transfer; open a gap before some bursts.
  task automatic send_sample(input logic signed [etcm_pkg::ElevW-1:0] elev);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_elevation_m <= elev;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic signed [etcm_pkg::ElevW-1:0] pick_elevation();
    int edges[5] = '{-etcm_pkg::DepthSat, 0, etcm_pkg::GreenTop, etcm_pkg::BrownTop,
                     etcm_pkg::ElevSat};
    case ($urandom_range(0, 9))
      0, 1:    return etcm_pkg::ElevW'($urandom);
      2:       return etcm_pkg::ElevW'(edges[$urandom_range(0, 4)] +
                                       int'($urandom_range(0, 6)) - 3);
      default: return etcm_pkg::ElevW'(int'($urandom_range(0, 15000)) - 6000);
    endcase
  endfunction

  // Stimulus
  initial begin : feed
    logic signed [etcm_pkg::ElevW-1:0] directed[$] = '{
      16'sh8000, -16'sd5001, -16'sd5000, -16'sd4999, -16'sd2500, -16'sd48, -16'sd1,
      16'sd0, 16'sd1, 16'sd47, 16'sd1599, 16'sd1600, 16'sd1601, 16'sd3200,
      16'sd4799, 16'sd4800, 16'sd4801, 16'sd6400, 16'sd7999, 16'sd8000, 16'sd8001,
      16'sd32767, 16'sh5555, -16'sh5556
    };
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_elevation_m = '0;
    burst_left     = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) send_sample(directed[i]);
    for (int n = 0; n < RandomSamples; n++) send_sample(pick_elevation());
    in_valid <= 1'b0;
    // let the checker record the last transfer before waiting on it
    @(posedge clk);
    wait (pixels_pending == 0);
    repeat (12) @(posedge clk);
    $display("Checked %0d pixels across water, lowland, mountain and snow bands,",
             pixels_checked);
    $display("with saturation edges, random bursts and long output back-pressure.");
    if (mismatches == 0 && pixels_pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Output back-pressure: random modes, plus a long hold-off now and then
  initial begin : drain
    drain_mode_t mode;
    int phase_len;
    int phase_no;
    out_stall = 1'b0;
    phase_no  = 0;
    wait (rst_n);
    forever begin
      phase_no++;
      if (phase_no % 11 == 4) begin
        @(posedge clk);
        out_stall <= 1'b1;
        repeat (LongHold) @(posedge clk);
      end
      mode      = drain_mode_t'($urandom_range(0, 3));
      phase_len = $urandom_range(20, 120);
      repeat (phase_len) begin
        @(posedge clk);
        case (mode)
          DRAIN_FREE:  out_stall <= 1'b0;
          DRAIN_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          DRAIN_HALF:  out_stall <= $urandom_range(0, 1);
          DRAIN_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:     out_stall <= 1'b0;
        endcase
      end
    end
  end

  // Watchdog: end the run if no transfer happens for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("%0t: no transfer for %0d cycles", $time, IdleLimit);
      $display("Some tests failed");
      $finish;
    end
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/etcm_pkg.sv
rtl/core/etcm_classify.sv
rtl/core/etcm_scale.sv
rtl/core/etcm_divide.sv
rtl/core/elevation_to_color_map.sv
verif/etcm_tint_checker.sv
verif/tb_elevation_to_color_map.sv
